// ----- hw/rtl/lsd_decimal_radix_sort_core_macros.svh -----
// assertion macros for the lsd decimal radix sort core
// expects clk and arst_n in the scope of each use
`ifndef LSD_DECIMAL_RADIX_SORT_CORE_MACROS_SVH
`define LSD_DECIMAL_RADIX_SORT_CORE_MACROS_SVH
`ifndef SYNTH
`define LSDRS_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsdrs check failed");
`define LSDRS_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsdrs check failed");
`else
`define LSDRS_IMPLY(label, ante, cons)
`define LSDRS_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/lsdrs_pkg.sv -----
// shared types and constants of the lsd decimal radix sort core
// no dependencies
package lsdrs_pkg;

	localparam int VAL_W       = 20;
	localparam int RADIX       = 10;
	localparam int DIGIT_W     = 4;
	localparam int CFG_W       = 3;
	localparam int PASS_CNT_W  = 4;
	localparam int DIV10_SHIFT = 23;
	localparam logic [VAL_W-1:0] DIV10_MUL = 20'd838861;
	localparam logic [CFG_W-1:0] PASSES_RST = 3'd3;
	localparam int MAX_ITEMS_DEF  = 64;
	localparam int MAX_DIGITS_DEF = 6;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLR,
		ST_H_RD,
		ST_H_DG,
		ST_H_AC,
		ST_PSUM,
		ST_S_RD,
		ST_S_DG,
		ST_S_AC,
		ST_C_RD,
		ST_C_WR,
		ST_O_RD,
		ST_O_LD,
		ST_O_WT
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_counts;
		logic dig;
		logic hist_inc;
		logic psum_step;
		logic scat;
		logic copy;
		logic idx_clr;
		logic idx_inc;
		logic idx_dec;
		logic idx_top;
		logic out_load;
		logic batch_clr;
	} cmd_t;

	typedef struct packed {
		logic is_last;
		logic idx_zero;
		logic psum_done;
		logic out_acc;
	} sts_t;

endpackage

// ----- hw/rtl/lsdrs_ctrl.sv -----
// sequencer of the lsd decimal radix sort core: load, passes, copy, unload
// depends on lsdrs_pkg
module lsdrs_ctrl #(
	parameter int MAX_DIGITS = lsdrs_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lsdrs_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        last,
	output logic                        in_stall,
	input  lsdrs_pkg::sts_t             sts,
	output lsdrs_pkg::cmd_t             cmd
);

	lsdrs_pkg::state_t state_q, state_d;
	logic [lsdrs_pkg::CFG_W-1:0]      passes_cfg_q;
	logic [lsdrs_pkg::PASS_CNT_W-1:0] pass_q, pass_d, eff;
	logic                             pass_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lsdrs_pkg::ST_LOAD;
			passes_cfg_q <= lsdrs_pkg::PASSES_RST;
			pass_q       <= '0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			if (cfg_wr_en) begin
				passes_cfg_q <= cfg_wr_data;
			end
		end
	end

	always_comb begin
		eff = lsdrs_pkg::PASS_CNT_W'(passes_cfg_q);
		if (passes_cfg_q == '0) begin
			eff = lsdrs_pkg::PASS_CNT_W'(1);
		end
		if (lsdrs_pkg::PASS_CNT_W'(MAX_DIGITS) < eff) begin
			eff = lsdrs_pkg::PASS_CNT_W'(MAX_DIGITS);
		end
		pass_final = (lsdrs_pkg::PASS_CNT_W'(pass_q + 1'b1) == eff);
	end

	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lsdrs_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
				if (in_valid && last) begin
					state_d = lsdrs_pkg::ST_CLR;
				end
			end
			lsdrs_pkg::ST_CLR: begin
				cmd.clr_counts = 1'b1;
				cmd.idx_clr    = 1'b1;
				state_d        = lsdrs_pkg::ST_H_RD;
			end
			lsdrs_pkg::ST_H_RD: state_d = lsdrs_pkg::ST_H_DG;
			lsdrs_pkg::ST_H_DG: begin
				cmd.dig = 1'b1;
				state_d = lsdrs_pkg::ST_H_AC;
			end
			lsdrs_pkg::ST_H_AC: begin
				cmd.hist_inc = 1'b1;
				if (sts.is_last) begin
					state_d = lsdrs_pkg::ST_PSUM;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = lsdrs_pkg::ST_H_RD;
				end
			end
			lsdrs_pkg::ST_PSUM: begin
				cmd.psum_step = 1'b1;
				if (sts.psum_done) begin
					cmd.idx_top = 1'b1;
					state_d     = lsdrs_pkg::ST_S_RD;
				end
			end
			lsdrs_pkg::ST_S_RD: state_d = lsdrs_pkg::ST_S_DG;
			lsdrs_pkg::ST_S_DG: begin
				cmd.dig = 1'b1;
				state_d = lsdrs_pkg::ST_S_AC;
			end
			lsdrs_pkg::ST_S_AC: begin
				cmd.scat = 1'b1;
				if (sts.idx_zero) begin
					state_d = lsdrs_pkg::ST_C_RD;
				end else begin
					cmd.idx_dec = 1'b1;
					state_d     = lsdrs_pkg::ST_S_RD;
				end
			end
			lsdrs_pkg::ST_C_RD: state_d = lsdrs_pkg::ST_C_WR;
			lsdrs_pkg::ST_C_WR: begin
				cmd.copy = 1'b1;
				if (sts.is_last) begin
					if (pass_final) begin
						pass_d      = '0;
						cmd.idx_clr = 1'b1;
						state_d     = lsdrs_pkg::ST_O_RD;
					end else begin
						pass_d  = lsdrs_pkg::PASS_CNT_W'(pass_q + 1'b1);
						state_d = lsdrs_pkg::ST_CLR;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = lsdrs_pkg::ST_C_RD;
				end
			end
			lsdrs_pkg::ST_O_RD: state_d = lsdrs_pkg::ST_O_LD;
			lsdrs_pkg::ST_O_LD: begin
				cmd.out_load = 1'b1;
				state_d      = lsdrs_pkg::ST_O_WT;
			end
			lsdrs_pkg::ST_O_WT: begin
				if (sts.out_acc) begin
					if (sts.is_last) begin
						cmd.batch_clr = 1'b1;
						cmd.idx_clr   = 1'b1;
						state_d       = lsdrs_pkg::ST_LOAD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = lsdrs_pkg::ST_O_RD;
					end
				end
			end
			default: state_d = lsdrs_pkg::ST_LOAD;
		endcase
	end

endmodule

// ----- hw/rtl/lsdrs_dp.sv -----
// datapath of the lsd decimal radix sort core: stores, digit unit, counts, output register
// depends on lsdrs_pkg and the assertion macro header
`include "lsd_decimal_radix_sort_core_macros.svh"

module lsdrs_dp #(
	parameter int MAX_ITEMS = lsdrs_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsdrs_pkg::cmd_t             cmd,
	output lsdrs_pkg::sts_t             sts,
	input  logic [lsdrs_pkg::VAL_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lsdrs_pkg::VAL_W-1:0] sorted_value,
	output logic                        final_res,
	output logic                        overflow
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int VW = lsdrs_pkg::VAL_W;
	localparam int EW = 2 * VW;
	localparam int QW = EW - lsdrs_pkg::DIV10_SHIFT;
	localparam int DW = lsdrs_pkg::DIGIT_W;

	// entry: value in the upper half, remaining quotient in the lower half
	logic [EW-1:0] item_mem [MAX_ITEMS];
	logic [EW-1:0] scr_mem  [MAX_ITEMS];
	logic [EW-1:0] item_rd_q, scr_rd_q;

	logic [CW-1:0] cnt_q, cnt_m1;
	logic [AW-1:0] idx_q;
	logic          ovf_q;
	logic [CW-1:0] cnts_q [lsdrs_pkg::RADIX];
	logic [DW-1:0] psum_q;
	logic [DW-1:0] digit_q;
	logic [VW-1:0] quo_q;

	logic [EW-1:0] prod;
	logic [QW-1:0] q10;
	logic [VW-1:0] q10x, rem_full;
	logic [CW-1:0] dec_cnt;
	logic          full, out_valid_q, final_q, ovf_out_q;
	logic [VW-1:0] out_val_q;

	assign cnt_m1   = cnt_q - 1'b1;
	assign full     = (cnt_q == CW'(MAX_ITEMS));
	assign prod     = EW'(item_rd_q[VW-1:0]) * EW'(lsdrs_pkg::DIV10_MUL);
	assign q10      = prod[EW-1:lsdrs_pkg::DIV10_SHIFT];
	assign q10x     = VW'(q10);
	assign rem_full = item_rd_q[VW-1:0] - ((q10x << 3) + (q10x << 1));
	assign dec_cnt  = cnts_q[digit_q] - 1'b1;

	assign sts.is_last   = (idx_q == cnt_m1[AW-1:0]);
	assign sts.idx_zero  = (idx_q == '0);
	assign sts.psum_done = (psum_q == DW'(lsdrs_pkg::RADIX - 1));
	assign sts.out_acc   = out_valid_q && !out_stall;

	always_ff @(posedge clk) begin
		item_rd_q <= item_mem[idx_q];
		scr_rd_q  <= scr_mem[idx_q];
		if (cmd.load && !full) begin
			item_mem[cnt_q[AW-1:0]] <= {value, value};
		end else if (cmd.copy) begin
			item_mem[idx_q] <= scr_rd_q;
		end
		if (cmd.scat) begin
			scr_mem[dec_cnt[AW-1:0]] <= {item_rd_q[EW-1:VW], quo_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dig) begin
			digit_q <= rem_full[DW-1:0];
			quo_q   <= q10x;
		end
		if (cmd.clr_counts) begin
			for (int d = 0; d < lsdrs_pkg::RADIX; d++) begin
				cnts_q[d] <= '0;
			end
		end else if (cmd.hist_inc) begin
			cnts_q[digit_q] <= CW'(cnts_q[digit_q] + 1'b1);
		end else if (cmd.psum_step) begin
			cnts_q[psum_q] <= CW'(cnts_q[psum_q] + cnts_q[DW'(psum_q - 1'b1)]);
		end else if (cmd.scat) begin
			cnts_q[digit_q] <= dec_cnt;
		end
		if (cmd.out_load) begin
			out_val_q <= item_rd_q[EW-1:VW];
			final_q   <= sts.is_last;
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			psum_q      <= DW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.batch_clr) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= CW'(cnt_q + 1'b1);
				end
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= AW'(idx_q + 1'b1);
			end else if (cmd.idx_dec) begin
				idx_q <= AW'(idx_q - 1'b1);
			end else if (cmd.idx_top) begin
				idx_q <= cnt_m1[AW-1:0];
			end
			if (cmd.clr_counts) begin
				psum_q <= DW'(1);
			end else if (cmd.psum_step) begin
				psum_q <= DW'(psum_q + 1'b1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (sts.out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_val_q;
	assign final_res    = final_q;
	assign overflow     = ovf_out_q;

	`LSDRS_IMPLY(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_ITEMS))
	`LSDRS_IMPLY(a_digit_range, cmd.hist_inc || cmd.scat, digit_q < DW'(lsdrs_pkg::RADIX))
	`LSDRS_IMPLY(a_scat_nonzero, cmd.scat, cnts_q[digit_q] != '0)
	`LSDRS_IMPLY(a_no_load_in_unload, out_valid_q, !cmd.load)

endmodule

// ----- hw/rtl/lsd_decimal_radix_sort_core.sv -----
// lsd decimal radix sort core, top level
// depends on lsdrs_pkg, lsdrs_ctrl, lsdrs_dp
//
// input channel (in_valid/in_stall, value, last): one beat per cycle while loading.
// a beat with last set starts the sort; beats beyond MAX_ITEMS are dropped and
// raise overflow, a dropped beat with last still starts the sort.
// cfg_wr_en/cfg_wr_data set the digit pass count (0 acts as 1, clamped to
// MAX_DIGITS); write only while the core is idle. reset value is 3.
// sort: each pass clears the counts once, builds the histogram, takes nine
// prefix-sum steps, scatters and copies back; histogram and scatter step
// through the single-port stores item by item (read, digit, accumulate).
// output channel (out_valid/out_stall, sorted_value, final_res, overflow): one
// beat per stored item, ascending by the sorted digits, final_res on the last;
// each beat goes through a store read, an output register load and the handoff.
// a stalled beat holds in the output register until taken. in_stall stays high
// from the last input beat until the final output beat is taken.
// reset clears the counters and the output valid; the stores need no clearing.
module lsd_decimal_radix_sort_core #(
	parameter int MAX_ITEMS  = lsdrs_pkg::MAX_ITEMS_DEF,
	parameter int MAX_DIGITS = lsdrs_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lsdrs_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lsdrs_pkg::VAL_W-1:0] value,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lsdrs_pkg::VAL_W-1:0] sorted_value,
	output logic                        final_res,
	output logic                        overflow
);

	lsdrs_pkg::cmd_t cmd;
	lsdrs_pkg::sts_t sts;

	lsdrs_ctrl #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.last        (last),
		.in_stall    (in_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	lsdrs_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow)
	);

endmodule
